[hdl/bcr_pkg.sv]
// Package for the Catmull-Rom bicubic interpolator: default widths, weight format,
// and row counter codes.
// No dependencies; imported by bicubic_catmull_rom_interp, bcr_weights and bcr_merge.
package bcr_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF   = 8;

	// Weights are Q2.14, held in 16 signed bits.
	localparam int WEIGHT_BITS = 14;
	localparam int WEIGHT_W    = WEIGHT_BITS + 2;

	localparam int ROW_CNT_W = 2;

	typedef logic signed [WEIGHT_W-1:0] weight_t;
	typedef logic [ROW_CNT_W-1:0]       row_cnt_t;

	// Three rows are kept. The row that arrives with this count is the fourth.
	localparam row_cnt_t LAST_ROW = row_cnt_t'(3);

endpackage

[hdl/bicubic_catmull_rom_interp.sv]
// Separable bicubic interpolator with Catmull-Rom weights. Each request carries one row of four
// samples with its fractions; the block takes one request per clock cycle while sample_stall is
// low. The row is filtered horizontally by four multiplier lanes. After three kept rows, the
// fourth row's partial is combined vertically by a second set of four lanes, and the merged sum
// is registered as the result. One result comes for every four requests.
// The pipeline moves as a whole. sample_stall is raised only while a finished result is held by
// result_stall. Depends on bcr_pkg, bcr_weights, bcr_lane and bcr_merge.
module bicubic_catmull_rom_interp #(
	parameter int SAMPLE_BITS = bcr_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = bcr_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample_0,
	input  logic signed [SAMPLE_BITS-1:0] sample_1,
	input  logic signed [SAMPLE_BITS-1:0] sample_2,
	input  logic signed [SAMPLE_BITS-1:0] sample_3,
	input  logic [FRAC_BITS-1:0]          frac_x,
	input  logic [FRAC_BITS-1:0]          frac_y,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic signed [SAMPLE_BITS:0]   interpolated
);
	import bcr_pkg::*;

	localparam int PART_BITS = SAMPLE_BITS + 2;
	localparam int OUT_BITS  = SAMPLE_BITS + 1;
	localparam int HPROD_W   = SAMPLE_BITS + WEIGHT_W;
	localparam int VPROD_W   = PART_BITS + WEIGHT_W;

	logic                          en;
	logic                          vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic                          result_valid_q;
	logic signed [SAMPLE_BITS-1:0] samp_s1 [4];
	logic signed [SAMPLE_BITS-1:0] samp_s2 [4];
	logic signed [SAMPLE_BITS-1:0] samp_s3 [4];
	logic signed [SAMPLE_BITS-1:0] samp_s4 [4];
	weight_t                       wx_s4 [4];
	weight_t                       wy_s4 [4];
	weight_t                       wy_s5 [4];
	weight_t                       wy_s6 [4];
	logic signed [HPROD_W-1:0]     hprod_s5 [4];
	logic signed [PART_BITS-1:0]   part_comb, part_s6;
	logic signed [PART_BITS-1:0]   vin [4];
	logic signed [VPROD_W-1:0]     vprod_s7 [4];
	logic signed [OUT_BITS-1:0]    res_comb, result_q;
	row_cnt_t                      row_count_q;
	logic signed [PART_BITS-1:0]   row_partials_q [3];
	logic                          launch;

	assign sample_stall = result_valid_q && result_stall;
	assign en           = !sample_stall;
	assign result_valid = result_valid_q;
	assign interpolated = result_q;
	assign launch       = vld_s6 && (row_count_q == LAST_ROW);

	bcr_weights #(.FRAC_BITS(FRAC_BITS)) u_wx (
		.clk(clk), .en(en), .frac(frac_x), .w_s4(wx_s4)
	);

	bcr_weights #(.FRAC_BITS(FRAC_BITS)) u_wy (
		.clk(clk), .en(en), .frac(frac_y), .w_s4(wy_s4)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			samp_s1[0] <= sample_0;
			samp_s1[1] <= sample_1;
			samp_s1[2] <= sample_2;
			samp_s1[3] <= sample_3;
			samp_s2    <= samp_s1;
			samp_s3    <= samp_s2;
			samp_s4    <= samp_s3;
			wy_s5      <= wy_s4;
			wy_s6      <= wy_s5;
			part_s6    <= part_comb;
			result_q   <= res_comb;
		end
	end

	generate
		for (genvar i = 0; i < 4; i++) begin : g_hlane
			bcr_lane #(.A_W(SAMPLE_BITS), .B_W(WEIGHT_W)) u_lane (
				.clk(clk), .en(en), .a(samp_s4[i]), .b(wx_s4[i]), .prod_q(hprod_s5[i])
			);
		end
	endgenerate

	bcr_merge #(.PROD_W(HPROD_W), .RES_W(PART_BITS)) u_hmerge (
		.prod(hprod_s5), .res(part_comb)
	);

	// The kept rows in arrival order, then the fourth row's partial straight from the pipeline.
	assign vin[0] = row_partials_q[0];
	assign vin[1] = row_partials_q[1];
	assign vin[2] = row_partials_q[2];
	assign vin[3] = part_s6;

	generate
		for (genvar i = 0; i < 4; i++) begin : g_vlane
			bcr_lane #(.A_W(PART_BITS), .B_W(WEIGHT_W)) u_lane (
				.clk(clk), .en(en), .a(vin[i]), .b(wy_s6[i]), .prod_q(vprod_s7[i])
			);
		end
	endgenerate

	bcr_merge #(.PROD_W(VPROD_W), .RES_W(OUT_BITS)) u_vmerge (
		.prod(vprod_s7), .res(res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1         <= 1'b0;
			vld_s2         <= 1'b0;
			vld_s3         <= 1'b0;
			vld_s4         <= 1'b0;
			vld_s5         <= 1'b0;
			vld_s6         <= 1'b0;
			vld_s7         <= 1'b0;
			result_valid_q <= 1'b0;
			row_count_q    <= '0;
		end else if (en) begin
			vld_s1         <= sample_valid;
			vld_s2         <= vld_s1;
			vld_s3         <= vld_s2;
			vld_s4         <= vld_s3;
			vld_s5         <= vld_s4;
			vld_s6         <= vld_s5;
			vld_s7         <= launch;
			result_valid_q <= vld_s7;
			// The count wraps from the fourth row back to zero.
			if (vld_s6) begin
				row_count_q <= row_count_q + row_cnt_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld_s6 && (row_count_q != LAST_ROW)) begin
			row_partials_q[row_count_q] <= part_s6;
		end
	end

	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> result_valid)
		else $error("input stalled without a held result");

	a_fourth_row_launches: assert property (@(posedge clk) disable iff (!arst_n)
		(en && launch) |=> (vld_s7 && (row_count_q == '0)))
		else $error("fourth row did not start the vertical pass");

	a_kept_row_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_s6 && (row_count_q != LAST_ROW)) |=>
		(!vld_s7 && (row_count_q == row_cnt_t'($past(row_count_q) + row_cnt_t'(1)))))
		else $error("kept row did not advance the row count");

endmodule

[hdl/bcr_weights.sv]
// Four-stage generator of the Catmull-Rom weights for one fraction.
// Each weight is formed exactly over 2*F^3 and then brought to Q2.14, rounded where it has more fraction bits.
// Depends on bcr_pkg.
module bcr_weights #(
	parameter int FRAC_BITS = bcr_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [FRAC_BITS-1:0] frac,
	output bcr_pkg::weight_t     w_s4 [4]
);
	import bcr_pkg::*;

	localparam int NUM_W = 3 * FRAC_BITS + 3;
	localparam int SH    = 3 * FRAC_BITS + 1 - WEIGHT_BITS;
	localparam logic signed [NUM_W-1:0] TWO_F3 = NUM_W'(1) <<< (3 * FRAC_BITS + 1);

	logic [FRAC_BITS-1:0]     f_s1, f_s2;
	logic [2*FRAC_BITS-1:0]   f2_s1, f2_s2;
	logic [3*FRAC_BITS-1:0]   f3_s2;
	logic signed [NUM_W-1:0]  num_s3 [4];
	logic signed [NUM_W-1:0]  fe, f2e, f3e, f_ff, f2_f;
	logic signed [NUM_W-1:0]  num [4];
	weight_t                  wv [4];

	always_ff @(posedge clk) begin
		if (en) begin
			f_s1   <= frac;
			f2_s1  <= frac * frac;
			f_s2   <= f_s1;
			f2_s2  <= f2_s1;
			f3_s2  <= f2_s1 * f_s1;
			num_s3 <= num;
			w_s4   <= wv;
		end
	end

	// Multiplications by powers of F are plain shifts.
	always_comb begin
		fe   = NUM_W'(f_s2);
		f2e  = NUM_W'(f2_s2);
		f3e  = NUM_W'(f3_s2);
		f_ff = fe <<< (2 * FRAC_BITS);
		f2_f = f2e <<< FRAC_BITS;
		num[0] = f2_f + f2_f - f_ff - f3e;
		num[1] = TWO_F3 - ((f2_f <<< 2) + f2_f) + ((f3e <<< 1) + f3e);
		num[2] = f_ff + (f2_f <<< 2) - ((f3e <<< 1) + f3e);
		num[3] = f3e - f2_f;
	end

	generate
		if (SH > 0) begin : g_round
			localparam logic signed [NUM_W-1:0] HALF = NUM_W'(1) <<< (SH - 1);
			logic signed [NUM_W-1:0] rnd [4];
			always_comb begin
				for (int i = 0; i < 4; i++) begin
					rnd[i] = (num_s3[i] + HALF) >>> SH;
					wv[i]  = WEIGHT_W'(rnd[i]);
				end
			end
		end else if (SH == 0) begin : g_exact
			always_comb begin
				for (int i = 0; i < 4; i++) begin
					wv[i] = WEIGHT_W'(num_s3[i]);
				end
			end
		end else begin : g_scale
			localparam int LSH = -SH;
			always_comb begin
				for (int i = 0; i < 4; i++) begin
					wv[i] = WEIGHT_W'(num_s3[i]) <<< LSH;
				end
			end
		end
	endgenerate

endmodule

[hdl/bcr_lane.sv]
// One filter lane: a registered signed product of a value and its weight.
// No dependencies.
module bcr_lane #(
	parameter int A_W = 16,
	parameter int B_W = 16
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic signed [A_W-1:0]       a,
	input  logic signed [B_W-1:0]       b,
	output logic signed [A_W+B_W-1:0]   prod_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

endmodule

[hdl/bcr_merge.sv]
// Merging stage: sums the four lane products, rounds away the Q2.14 weight scale
// (half towards plus infinity) and saturates to the result width.
// Depends on bcr_pkg.
module bcr_merge #(
	parameter int PROD_W = 32,
	parameter int RES_W  = 18
) (
	input  logic signed [PROD_W-1:0] prod [4],
	output logic signed [RES_W-1:0]  res
);
	import bcr_pkg::*;

	localparam int SUM_W = PROD_W + 3;
	localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (WEIGHT_BITS - 1);

	logic signed [SUM_W-1:0] sum, shifted;
	logic [SUM_W-RES_W:0]    upper;

	always_comb begin
		sum     = SUM_W'(prod[0]) + SUM_W'(prod[1]) + SUM_W'(prod[2]) + SUM_W'(prod[3]) + HALF;
		shifted = sum >>> WEIGHT_BITS;
		upper   = shifted[SUM_W-1:RES_W-1];
		// The value fits when every bit above the result's sign equals that sign.
		if ((&upper) || !(|upper)) begin
			res = shifted[RES_W-1:0];
		end else if (shifted[SUM_W-1]) begin
			res = {1'b1, {(RES_W-1){1'b0}}};
		end else begin
			res = {1'b0, {(RES_W-1){1'b1}}};
		end
	end

endmodule
